// ===== src/stl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lexer package
// Token kinds, scanner modes and the small character tables of the lexer.
// ----------------------------------------------------------------------------
package stl_pkg;

  typedef enum logic [3:0] {
    M_IDLE, M_IDLE_SKIP, M_OP, M_DOT, M_INT, M_INT_DOT, M_FRAC,
    M_IDENT, M_STRING, M_LINE, M_BLOCK, M_BLOCK_STAR
  } mode_e;

  localparam logic [5:0] K_END = 6'd0, K_LPAREN = 6'd1, K_RPAREN = 6'd2,
    K_LBRACE = 6'd3, K_LSQUARE = 6'd4, K_RSQUARE = 6'd5, K_RBRACE = 6'd6,
    K_COMMA = 6'd7, K_DOT = 6'd8, K_MINUS_EQ = 6'd9, K_MINUS = 6'd10,
    K_PLUS_EQ = 6'd11, K_PLUS = 6'd12, K_SEMI = 6'd13, K_STAR_EQ = 6'd14,
    K_STAR = 6'd15, K_BANG_EQ = 6'd16, K_BANG = 6'd17, K_EQ_EQ = 6'd18,
    K_ARROW = 6'd19, K_EQ = 6'd20, K_LESS_EQ = 6'd21, K_LESS = 6'd22,
    K_GREATER_EQ = 6'd23, K_GREATER = 6'd24, K_COLON = 6'd25,
    K_QUESTION = 6'd26, K_SLASH_EQ = 6'd27, K_SLASH = 6'd28,
    K_MOD_EQ = 6'd29, K_MOD = 6'd30, K_OR = 6'd31, K_BIN_OR = 6'd32,
    K_AND = 6'd33, K_BIN_AND = 6'd34, K_ERROR = 6'd35, K_STRING = 6'd36,
    K_FLOAT = 6'd37, K_INT = 6'd38, K_IDENT = 6'd56;

  localparam logic [1:0] E_NONE = 2'd0, E_CHAR = 2'd1, E_STR = 2'd2,
    E_CMT = 2'd3;

  // Carriage return, which has no portable string escape.
  localparam logic [7:0] ChCr = 8'h0D;

  localparam int MaxRes = 4;
  localparam int KwMaxLen = 8;

  // One token before its position fields are narrowed to the port width.
  typedef struct packed {
    logic [5:0]  kind;
    logic [1:0]  err;
    logic [31:0] start;
    logic [31:0] len;
  } tok_t;

  function automatic logic is_num_char(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_word_char(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic [5:0] single_kind(input logic [7:0] h);
    case (h)
      "-": return K_MINUS;
      "+": return K_PLUS;
      "*": return K_STAR;
      "!": return K_BANG;
      "=": return K_EQ;
      "<": return K_LESS;
      ">": return K_GREATER;
      "/": return K_SLASH;
      "%": return K_MOD;
      "|": return K_BIN_OR;
      default: return K_BIN_AND;
    endcase
  endfunction

  // Returns K_END when the pair forms no operator.
  function automatic logic [5:0] pair_kind(input logic [7:0] h, input logic [7:0] c);
    logic [5:0] k;
    k = K_END;
    if (h == "|") k = (c == "|") ? K_OR : K_END;
    else if (h == "&") k = (c == "&") ? K_AND : K_END;
    else if (h == "=" && c == ">") k = K_ARROW;
    else if (c == "=") begin
      case (h)
        "-": k = K_MINUS_EQ;
        "+": k = K_PLUS_EQ;
        "*": k = K_STAR_EQ;
        "!": k = K_BANG_EQ;
        "=": k = K_EQ_EQ;
        "<": k = K_LESS_EQ;
        ">": k = K_GREATER_EQ;
        "/": k = K_SLASH_EQ;
        default: k = K_MOD_EQ;
      endcase
    end
    return k;
  endfunction

  function automatic logic [5:0] ident_kind(input logic [63:0] w);
    case (w)
      64'h616e64:           return K_AND;
      64'h636c617373:       return 6'd39;
      64'h636f6e74696e7565: return 6'd40;
      64'h656c7365:         return 6'd41;
      64'h646566:           return 6'd42;
      64'h666f72:           return 6'd43;
      64'h66616c7365:       return 6'd44;
      64'h6966:             return 6'd45;
      64'h6e756c6c:         return 6'd46;
      64'h72657475726e:     return 6'd47;
      64'h7375706572:       return 6'd48;
      64'h6f72:             return K_OR;
      64'h74686973:         return 6'd49;
      64'h74727565:         return 6'd50;
      64'h6c616d626461:     return 6'd51;
      64'h7768696c65:       return 6'd52;
      64'h627265616b:       return 6'd53;
      64'h766172:           return 6'd54;
      64'h636f6e7374:       return 6'd55;
      default:              return K_IDENT;
    endcase
  endfunction

endpackage

// ===== src/source_token_lexer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lexer core top level
// A token passes through the byte register and then the output queue.
// Throughput: one source byte per cycle while the eight-entry output queue
// drains; up to four tokens per byte leave, one per ready cycle, and a byte is
// refused while the queue plus the tokens being pushed exceed four entries.
// Reset clears the scanner to idle, offset zero, line one, and empties
// the queue. The scanner also returns to reset values after each final byte.
// ----------------------------------------------------------------------------
module source_token_lexer_core import stl_pkg::*; #(
  parameter int OFFSET_BITS = 24,
  parameter int LINE_BITS   = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // source_byte
  input  logic        s_axis_tlast,   // end_of_source
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // token_kind[5:0], error_code[7:6], lexeme_start[31:8],
  // lexeme_length[55:32], line_number[75:56], zero fill to 80
  output logic [79:0] m_axis_tdata,
  output logic        m_axis_tlast    // last_token
);

  localparam int W = 77;

  mode_e mode_q, mode_d;
  logic [7:0] hold_q, hold_d, quote_q, quote_d, b_q;
  logic [OFFSET_BITS-1:0] start_q, start_d, off_q, off_d;
  logic [LINE_BITS-1:0] line_q, line_d;
  logic [MaxRes-1:0][LINE_BITS-1:0] tline;
  logic [63:0] win_q, win_d;
  logic in_q, eos_q, space;
  tok_t [MaxRes-1:0] tok;
  logic [MaxRes-1:0] tval, lastv;
  logic [MaxRes-1:0][W-1:0] pdata;
  logic [W-1:0] qd;

  assign s_axis_tready = space;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q <= 1'b0;
    end else begin
      in_q <= s_axis_tvalid && space;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && space) begin
      b_q <= s_axis_tdata; eos_q <= s_axis_tlast;
    end
  end

  stl_scan #(.OffBits(OFFSET_BITS), .LineBits(LINE_BITS)) u_scan (
    .byte_i(b_q), .eos_i(eos_q), .mode_i(mode_q), .hold_i(hold_q),
    .quote_i(quote_q), .start_i(start_q), .off_i(off_q), .line_i(line_q),
    .win_i(win_q), .mode_o(mode_d), .hold_o(hold_d), .quote_o(quote_d),
    .start_o(start_d), .off_o(off_d), .line_o(line_d), .win_o(win_d),
    .tok_o(tok), .tval_o(tval), .tline_o(tline)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE; hold_q <= '0; quote_q <= '0; start_q <= '0;
      off_q <= '0; line_q <= LINE_BITS'(1); win_q <= '0;
    end else if (in_q) begin
      mode_q <= mode_d; hold_q <= hold_d; quote_q <= quote_d;
      start_q <= start_d; off_q <= off_d; line_q <= line_d; win_q <= win_d;
    end
  end

  always_comb begin
    for (int i = 0; i < MaxRes; i++) begin
      lastv[i] = eos_q && tval[i] && (i == MaxRes - 1 || !tval[(i + 1) % MaxRes]);
      pdata[i] = {lastv[i], 20'(tline[i]), tok[i].len[23:0], tok[i].start[23:0],
                  tok[i].err, tok[i].kind};
    end
  end

  stl_outq #(.W(W)) u_q (
    .clk_i(clk_i), .rst_ni(rst_ni), .push_i(in_q), .pval_i(tval),
    .pdata_i(pdata), .space_o(space), .valid_o(m_axis_tvalid), .data_o(qd),
    .ready_i(m_axis_tready)
  );

  assign m_axis_tdata = {4'd0, qd[75:0]};
  assign m_axis_tlast = qd[76];

endmodule

// ===== src/stl_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lexer scan step
// Combinational next state and up to four tokens for one source byte.
// ----------------------------------------------------------------------------
module stl_scan import stl_pkg::*; #(
  parameter int OffBits  = 24,
  parameter int LineBits = 20
) (
  input  logic [7:0]          byte_i,
  input  logic                eos_i,
  input  mode_e               mode_i,
  input  logic [7:0]          hold_i,
  input  logic [7:0]          quote_i,
  input  logic [OffBits-1:0]  start_i,
  input  logic [OffBits-1:0]  off_i,
  input  logic [LineBits-1:0] line_i,
  input  logic [63:0]         win_i,
  output mode_e               mode_o,
  output logic [7:0]          hold_o,
  output logic [7:0]          quote_o,
  output logic [OffBits-1:0]  start_o,
  output logic [OffBits-1:0]  off_o,
  output logic [LineBits-1:0] line_o,
  output logic [63:0]         win_o,
  output tok_t [MaxRes-1:0]   tok_o,
  output logic [MaxRes-1:0]   tval_o,
  output logic [MaxRes-1:0][LineBits-1:0] tline_o
);

  localparam logic [OffBits-1:0]  OffTop  = '1;
  localparam logic [LineBits-1:0] LineTop = '1;

  logic [OffBits-1:0] pos, nxt, dot, sp, tend;
  logic [5:0] pk;
  logic do_idle;
  logic [2:0] n;

  function automatic logic [31:0] span(input logic [OffBits-1:0] a,
                                       input logic [OffBits-1:0] b);
    return (b > a) ? 32'(b - a) : 32'd0;
  endfunction

  always_comb begin
    pos = off_i;
    nxt = (pos < OffTop) ? pos + 1'b1 : OffTop;
    tend = nxt;
    mode_o = mode_i;
    hold_o = hold_i;
    quote_o = quote_i;
    start_o = start_i;
    line_o = line_i;
    win_o = win_i;
    tok_o = '0;
    tval_o = '0;
    n = '0;
    do_idle = 1'b0;
    dot = '0;
    sp = '0;
    pk = pair_kind(hold_i, byte_i);
    tline_o = {MaxRes{line_i}};

    case (mode_i)
      M_OP: begin
        hold_o = '0;
        if (hold_i == "/" && byte_i == "/") mode_o = M_LINE;
        else if (hold_i == "/" && byte_i == "*") mode_o = M_BLOCK;
        else if (pk != K_END) begin
          tok_o[0] = '{pk, E_NONE, 32'(start_i), span(start_i, nxt)};
          tval_o[0] = 1'b1; n = 3'd1; mode_o = M_IDLE;
        end else begin
          tok_o[0] = '{single_kind(hold_i), E_NONE, 32'(start_i), span(start_i, pos)};
          tval_o[0] = 1'b1; n = 3'd1; do_idle = 1'b1;
        end
      end
      M_DOT: begin
        hold_o = '0;
        if (is_num_char(byte_i)) mode_o = M_FRAC;
        else begin
          tok_o[0] = '{K_DOT, E_NONE, 32'(start_i), span(start_i, pos)};
          tval_o[0] = 1'b1; n = 3'd1; do_idle = 1'b1;
        end
      end
      M_INT: begin
        if (byte_i == ".") begin
          hold_o = byte_i; mode_o = M_INT_DOT;
        end else if (!is_num_char(byte_i)) begin
          tok_o[0] = '{K_INT, E_NONE, 32'(start_i), span(start_i, pos)};
          tval_o[0] = 1'b1; n = 3'd1; do_idle = 1'b1;
        end
      end
      M_INT_DOT: begin
        hold_o = '0;
        if (is_word_char(byte_i)) begin
          dot = (pos > start_i) ? pos - 1'b1 : start_i;
          tok_o[0] = '{K_INT, E_NONE, 32'(start_i), span(start_i, dot)};
          tok_o[1] = '{K_DOT, E_NONE, 32'(dot), span(dot, pos)};
          tval_o[1:0] = 2'b11; n = 3'd2; do_idle = 1'b1;
        end else if (is_num_char(byte_i)) mode_o = M_FRAC;
        else begin
          tok_o[0] = '{K_FLOAT, E_NONE, 32'(start_i), span(start_i, pos)};
          tval_o[0] = 1'b1; n = 3'd1; do_idle = 1'b1;
        end
      end
      M_FRAC: begin
        if (!is_num_char(byte_i)) begin
          tok_o[0] = '{K_FLOAT, E_NONE, 32'(start_i), span(start_i, pos)};
          tval_o[0] = 1'b1; n = 3'd1; do_idle = 1'b1;
        end
      end
      M_IDENT: begin
        if (is_word_char(byte_i) || is_num_char(byte_i)) begin
          if (win_i[63:56] != '0) win_o = '1;
          else win_o = {win_i[55:0], byte_i};
        end else begin
          tok_o[0] = '{ident_kind(win_i), E_NONE, 32'(start_i), span(start_i, pos)};
          tval_o[0] = 1'b1; n = 3'd1; do_idle = 1'b1;
        end
      end
      M_STRING: begin
        if (byte_i == quote_i) begin
          sp = (start_i < OffTop) ? start_i + 1'b1 : OffTop;
          tok_o[0] = '{K_STRING, E_NONE, 32'(sp), span(sp, pos)};
          tval_o[0] = 1'b1; n = 3'd1; mode_o = M_IDLE;
        end else if (byte_i == "\n") begin
          tok_o[0] = '{K_ERROR, E_STR, 32'(start_i), span(start_i, pos)};
          tval_o[0] = 1'b1; n = 3'd1; do_idle = 1'b1;
        end
      end
      M_LINE: if (byte_i == "\n") do_idle = 1'b1;
      M_BLOCK, M_BLOCK_STAR: begin
        if (mode_i == M_BLOCK_STAR && byte_i == "/") mode_o = M_IDLE_SKIP;
        else begin
          if (byte_i == "\n" && line_i < LineTop) line_o = line_i + 1'b1;
          mode_o = (byte_i == "*") ? M_BLOCK_STAR : M_BLOCK;
        end
      end
      default: do_idle = 1'b1;
    endcase

    // Tokens emitted above carry the line before this byte is counted.
    if (do_idle) begin
      mode_o = M_IDLE;
      case (byte_i)
        " ", ChCr, "\t": mode_o = M_IDLE_SKIP;
        "\n": begin
          if (line_i < LineTop) line_o = line_i + 1'b1;
          mode_o = M_IDLE_SKIP;
        end
        "-", "+", "*", "!", "=", "<", ">", "/", "%", "|", "&": begin
          start_o = pos; hold_o = byte_i; mode_o = M_OP;
        end
        ".": begin
          start_o = pos; hold_o = byte_i; mode_o = M_DOT;
        end
        "\"", "'": begin
          start_o = pos; quote_o = byte_i; mode_o = M_STRING;
        end
        "(", ")", "{", "[", "]", "}", ",", ";", ":", "?": begin
          tok_o[n[1:0]].err = E_NONE;
          tok_o[n[1:0]].start = 32'(pos);
          tok_o[n[1:0]].len = span(pos, nxt);
          case (byte_i)
            "(": tok_o[n[1:0]].kind = K_LPAREN;
            ")": tok_o[n[1:0]].kind = K_RPAREN;
            "{": tok_o[n[1:0]].kind = K_LBRACE;
            "[": tok_o[n[1:0]].kind = K_LSQUARE;
            "]": tok_o[n[1:0]].kind = K_RSQUARE;
            "}": tok_o[n[1:0]].kind = K_RBRACE;
            ",": tok_o[n[1:0]].kind = K_COMMA;
            ";": tok_o[n[1:0]].kind = K_SEMI;
            ":": tok_o[n[1:0]].kind = K_COLON;
            default: tok_o[n[1:0]].kind = K_QUESTION;
          endcase
          tval_o[n[1:0]] = 1'b1; n = n + 1'b1;
        end
        default: begin
          start_o = pos;
          if (is_num_char(byte_i)) mode_o = M_INT;
          else if (is_word_char(byte_i)) begin
            win_o = {56'd0, byte_i}; mode_o = M_IDENT;
          end else begin
            tok_o[n[1:0]] = '{K_ERROR, E_CHAR, 32'(pos), span(pos, nxt)};
            tval_o[n[1:0]] = 1'b1; n = n + 1'b1;
          end
        end
      endcase
    end

    off_o = nxt;

    // End of source: flush what is pending, then return to reset values.
    // The flushed token carries the line after this byte is counted.
    if (eos_i) begin
      tok_o[n[1:0]].start = 32'(start_o);
      tok_o[n[1:0]].len = span(start_o, tend);
      tok_o[n[1:0]].err = E_NONE;
      tok_o[n[1:0]].kind = K_END;
      case (mode_o)
        M_IDLE_SKIP, M_LINE: begin
          tok_o[n[1:0]].start = 32'(tend); tok_o[n[1:0]].len = '0;
          tval_o[n[1:0]] = 1'b1;
        end
        M_OP: begin
          tok_o[n[1:0]].kind = single_kind(hold_o); tval_o[n[1:0]] = 1'b1;
        end
        M_DOT: begin tok_o[n[1:0]].kind = K_DOT; tval_o[n[1:0]] = 1'b1; end
        M_INT: begin tok_o[n[1:0]].kind = K_INT; tval_o[n[1:0]] = 1'b1; end
        M_INT_DOT, M_FRAC: begin
          tok_o[n[1:0]].kind = K_FLOAT; tval_o[n[1:0]] = 1'b1;
        end
        M_IDENT: begin
          tok_o[n[1:0]].kind = ident_kind(win_o); tval_o[n[1:0]] = 1'b1;
        end
        M_STRING: begin
          tok_o[n[1:0]].kind = K_ERROR; tok_o[n[1:0]].err = E_STR;
          tval_o[n[1:0]] = 1'b1;
        end
        M_BLOCK, M_BLOCK_STAR: begin
          tok_o[n[1:0]].kind = K_ERROR; tok_o[n[1:0]].err = E_CMT;
          tval_o[n[1:0]] = 1'b1;
        end
        default: ;
      endcase
      tline_o[n[1:0]] = line_o;
      mode_o = M_IDLE; hold_o = '0; quote_o = '0; start_o = '0;
      off_o = '0; line_o = LineBits'(1); win_o = '0;
    end
  end

endmodule

// ===== src/stl_outq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lexer output queue
// Holds the tokens of one or more bytes; drains one per cycle while ready_i is high.
// ----------------------------------------------------------------------------
module stl_outq import stl_pkg::*; #(
  parameter int W = 96
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  logic [MaxRes-1:0] pval_i,
  input  logic [MaxRes-1:0][W-1:0] pdata_i,
  output logic           space_o,
  output logic           valid_o,
  output logic [W-1:0]   data_o,
  input  logic           ready_i
);

  // Eight entries: room for two full bytes, so one byte can be taken per cycle while tokens drain.
  localparam int Depth = 8;
  logic [Depth-1:0][W-1:0] mem_q;
  logic [2:0] wp_q, rp_q, wp_d;
  logic [3:0] cnt_q, cnt_d;
  logic [2:0] npush;
  logic pop;

  always_comb begin
    npush = '0;
    for (int i = 0; i < MaxRes; i++) npush = npush + 3'(pval_i[i] & push_i);
    pop = valid_o && ready_i;
    cnt_d = cnt_q + 4'(npush) - 4'(pop);
    wp_d = wp_q + npush;
  end

  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rp_q];
  // The byte taken now is pushed next cycle, after the push in progress.
  assign space_o = (cnt_q + 4'(npush)) <= 4'(Depth - MaxRes);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      wp_q <= wp_d; cnt_q <= cnt_d;
      if (pop) rp_q <= rp_q + 1'b1;
    end
  end

  // Valid tokens are always packed from slot zero up.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxRes; i++)
      if (push_i && pval_i[i]) mem_q[wp_q + 3'(i)] <= pdata_i[i];
  end

endmodule
